>>> rtl/dsf_pkg.sv
`default_nettype none
package dsf_pkg;

  // Fixed-point format
  localparam int FRAC_BITS = 16;
  localparam logic [63:0] ONE = 64'(1) << FRAC_BITS;

  // Field widths
  localparam int POS_W   = 32;
  localparam int DT_W    = 16;
  localparam int DZW_W   = 24;
  localparam int ST_W    = 23;
  localparam int CFG_W   = 24;
  localparam int HALF_W  = DZW_W - 1;

  // Derived datapath widths
  localparam int OMEGA_W = 31;
  localparam int DECAY_W = FRAC_BITS + 1;
  localparam int LIM_W   = 30;

  // Constants rounded to nearest in the fixed-point format
  localparam logic [63:0] ST_FLOOR_RAW = (ONE + 64'd5000) / 64'd10000;
  localparam logic [63:0] ST_FLOOR     = (ST_FLOOR_RAW != 0) ? ST_FLOOR_RAW : 64'd1;
  localparam logic [63:0] C048         = (64'd48 * ONE + 64'd50) / 64'd100;
  localparam logic [63:0] C235         = (64'd235 * ONE + 64'd500) / 64'd1000;
  localparam logic [63:0] X_CAP        = 64'd1024 * ONE;
  localparam logic [63:0] LIM_SCALE    = 64'd100;

  // Divide by five through a reciprocal, exact for operands below 2^32
  localparam logic [31:0] RECIP5    = 32'hCCCCCCCD;
  localparam int          RECIP5_SH = 34;

  // Arithmetic unit widths, used by every multiplier and divider
  localparam int MUL_A_W   = 64;
  localparam int MUL_B_W   = 32;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CHUNK = 16;
  localparam int DIV_W     = 48;

  // Register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DZ_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = 2'd2;

  typedef struct packed {
    logic                    target_valid;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic [DT_W-1:0]         frame_time;
  } in_t;

  typedef struct packed {
    logic signed [POS_W-1:0] camera_x;
    logic signed [POS_W-1:0] camera_y;
    logic                    moved;
  } out_t;

  // Values shared by both axes for one update
  typedef struct packed {
    logic [OMEGA_W-1:0] omega;
    logic [DECAY_W-1:0] decay;
    logic [DT_W-1:0]    dt;
    logic [LIM_W-1:0]   lim;
  } common_t;

  typedef struct packed {
    logic                    busy;
    logic signed [POS_W-1:0] pos;
  } lane_stat_t;

  function automatic logic signed [POS_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return hi[POS_W-1:0];
    if (v < lo) return lo[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/deadzone_smoothdamp_follow.sv
`default_nettype none
// Two-axis deadzone follower with critically damped smoothing, signed Q16.16. One item in
// gives one result out. An item is taken only while the block is idle; a result waiting
// in the output register does not block the next item. A hold item (no target or zero
// frame time) goes straight to the output step, and the next item can be taken once its
// result is registered. An update first works out the shared terms: a division for
// omega, five multiplies for the decay polynomial and a second division for the decay;
// when the decay argument reaches its cap, the rest of the polynomial and the decay
// division are skipped and the decay is zero. Then both axes run in parallel lanes, each
// with up to nine multiplies and one division for the soft deadzone edge. The next item
// can be taken once the result is registered. The multipliers retire 16 x 32 bits a
// cycle; the restoring dividers take most of an update's time.
module deadzone_smoothdamp_follow (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire dsf_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output dsf_pkg::out_t                       out_data,
  input  wire logic                           cfg_we,
  input  wire logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dsf_pkg::CFG_W-1:0]      cfg_data
);
  import dsf_pkg::*;

  localparam int F = FRAC_BITS;

  typedef enum logic [3:0] {
    T_IDLE, T_OMEGA, T_X, T_X2, T_X3, T_T48, T_T235, T_DECAY, T_GO, T_WAIT, T_FIN
  } top_state_t;

  top_state_t state;
  logic       wait_q;

  // Configuration
  logic [DZW_W-1:0] dz_x;
  logic [DZW_W-1:0] dz_y;
  logic [ST_W-1:0]  smooth;

  // Per-item registers
  in_t                item;
  logic               moved;
  logic [ST_W-1:0]    st;
  logic [LIM_W-1:0]   lim;
  logic [OMEGA_W-1:0] omega;
  logic [DECAY_W-1:0] decay;
  logic [30:0]        x;
  logic [35:0]        x2;
  logic [45:0]        x3;
  logic [34:0]        t48;
  logic [43:0]        t235;

  logic [ST_W-1:0]    st_in;
  logic [DIV_W-1:0]   den;
  logic [30:0]        x_new;

  // Shared units for the common terms
  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_W-1:0]   div_n, div_d, div_q;

  dsf_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p),
                 .done(mul_done));
  dsf_div u_div (.clk, .rst, .start(div_start), .dividend(div_n), .divisor(div_d),
                 .q(div_q), .done(div_done));

  // Lanes
  common_t    com;
  logic       lane_go;
  lane_stat_t stat_x, stat_y;

  assign com.omega = omega;
  assign com.decay = decay;
  assign com.dt    = item.frame_time;
  assign com.lim   = lim;
  assign lane_go   = (state == T_GO);

  dsf_lane u_lane_x (.clk, .rst, .start(lane_go), .com, .target(item.target_x),
                     .half(dz_x[DZW_W-1:1]), .stat(stat_x));
  dsf_lane u_lane_y (.clk, .rst, .start(lane_go), .com, .target(item.target_y),
                     .half(dz_y[DZW_W-1:1]), .stat(stat_y));

  always_comb begin
    st_in = (64'(smooth) < ST_FLOOR) ? ST_W'(ST_FLOOR) : smooth;
    den   = DIV_W'(ONE) + DIV_W'(x) + DIV_W'(t48) + DIV_W'(t235);
    x_new = mul_p[F +: 31];
    mul_a = '0;
    mul_b = '0;
    case (state)
      T_X:    begin mul_a = MUL_A_W'(omega); mul_b = MUL_B_W'(item.frame_time); end
      T_X2:   begin mul_a = MUL_A_W'(x);     mul_b = MUL_B_W'(x); end
      T_X3:   begin mul_a = MUL_A_W'(x2);    mul_b = MUL_B_W'(x); end
      T_T48:  begin mul_a = MUL_A_W'(x2);    mul_b = MUL_B_W'(C048); end
      T_T235: begin mul_a = MUL_A_W'(x3);    mul_b = MUL_B_W'(C235); end
      default: ;
    endcase
    if (state == T_OMEGA) begin
      div_n = DIV_W'(64'(2) << (2 * F));
      div_d = DIV_W'(st);
    end else begin
      div_n = DIV_W'(ONE << F);
      div_d = den;
    end
  end

  assign mul_start = !wait_q && (state inside {T_X, T_X2, T_X3, T_T48, T_T235});
  assign div_start = !wait_q && (state == T_OMEGA || state == T_DECAY);
  assign in_stall  = (state != T_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      dz_x   <= '0;
      dz_y   <= '0;
      smooth <= ST_W'(ONE);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DZ_X:   dz_x   <= cfg_data;
        REG_DZ_Y:   dz_y   <= cfg_data;
        REG_SMOOTH: smooth <= cfg_data[ST_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      wait_q    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mul_start || div_start) wait_q <= 1'b1;
      if (mul_done || div_done)   wait_q <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        T_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            st    <= st_in;
            lim   <= LIM_W'(LIM_W'(st_in) * LIM_W'(LIM_SCALE));
            moved <= in_data.target_valid && (in_data.frame_time != '0);
            if (in_data.target_valid && (in_data.frame_time != '0)) state <= T_OMEGA;
            else state <= T_FIN;
          end
        end
        T_OMEGA: begin
          if (div_done) begin
            omega <= div_q[OMEGA_W-1:0];
            state <= T_X;
          end
        end
        T_X: begin
          if (mul_done) begin
            x <= x_new;
            if (64'(x_new) >= X_CAP) begin
              decay <= '0;
              state <= T_GO;
            end else begin
              state <= T_X2;
            end
          end
        end
        T_X2: begin
          if (mul_done) begin
            x2    <= mul_p[F +: 36];
            state <= T_X3;
          end
        end
        T_X3: begin
          if (mul_done) begin
            x3    <= mul_p[F +: 46];
            state <= T_T48;
          end
        end
        T_T48: begin
          if (mul_done) begin
            t48   <= mul_p[F +: 35];
            state <= T_T235;
          end
        end
        T_T235: begin
          if (mul_done) begin
            t235  <= mul_p[F +: 44];
            state <= T_DECAY;
          end
        end
        T_DECAY: begin
          if (div_done) begin
            decay <= div_q[DECAY_W-1:0];
            state <= T_GO;
          end
        end
        T_GO: state <= T_WAIT;
        T_WAIT: begin
          if (!stat_x.busy && !stat_y.busy) state <= T_FIN;
        end
        T_FIN: begin
          // Merge both axes into the result item
          if (!out_valid || !out_stall) begin
            out_data.camera_x <= stat_x.pos;
            out_data.camera_y <= stat_y.pos;
            out_data.moved    <= moved;
            out_valid         <= 1'b1;
            state             <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/dsf_mul.sv
`default_nettype none
// Sequential unsigned multiplier: one 16 x 32 partial product per cycle, MSB chunk first
module dsf_mul (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [dsf_pkg::MUL_A_W-1:0] a,
  input  wire logic [dsf_pkg::MUL_B_W-1:0] b,
  output logic      [dsf_pkg::MUL_P_W-1:0] p,
  output logic                             done
);
  import dsf_pkg::*;

  localparam int STEPS = MUL_A_W / MUL_CHUNK;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam int PP_W  = MUL_CHUNK + MUL_B_W;

  logic [MUL_A_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_r;
  logic [MUL_P_W-1:0] acc;
  logic [CNT_W-1:0]   cnt;
  logic [PP_W-1:0]    pp;

  assign pp = a_sh[MUL_A_W-1 -: MUL_CHUNK] * b_r;
  assign p  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_sh <= a;
        b_r  <= b;
        acc  <= '0;
        cnt  <= CNT_W'(STEPS);
      end else if (cnt != '0) begin
        acc  <= (acc << MUL_CHUNK) + MUL_P_W'(pp);
        a_sh <= a_sh << MUL_CHUNK;
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/dsf_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle
module dsf_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [dsf_pkg::DIV_W-1:0] dividend,
  input  wire logic [dsf_pkg::DIV_W-1:0] divisor,
  output logic      [dsf_pkg::DIV_W-1:0] q,
  output logic                           done
);
  import dsf_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W:0]   trial;
  logic             fits;

  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign q     = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        rem <= fits ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        quo <= {quo[DIV_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/dsf_lane.sv
`default_nettype none
// One axis: soft deadzone aim point, then the damped spring step. Holds pos and vel.
module dsf_lane (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire dsf_pkg::common_t               com,
  input  wire logic signed [dsf_pkg::POS_W-1:0] target,
  input  wire logic [dsf_pkg::HALF_W-1:0]     half,
  output dsf_pkg::lane_stat_t                 stat
);
  import dsf_pkg::*;

  localparam int F = FRAC_BITS;

  typedef enum logic [3:0] {
    L_IDLE, L_DZ, L_EDGE, L_TDIV, L_T2, L_S, L_M, L_CHG,
    L_OC, L_TEMP, L_OT, L_NV, L_OUT, L_FIN
  } lane_state_t;

  lane_state_t state;
  logic        wait_q;

  logic signed [POS_W-1:0] pos;
  logic signed [POS_W-1:0] vel;
  logic signed [POS_W-1:0] tgt;
  logic [32:0]             over;
  logic                    neg;
  logic [HALF_W-1:0]       edge_w;
  logic [F:0]              t;
  logic [F:0]              t2;
  logic [F:0]              s_f;
  logic signed [33:0]      aim;
  logic signed [30:0]      chg;
  logic signed [33:0]      goal;
  logic signed [47:0]      sum1;
  logic signed [46:0]      tmp;
  logic signed [62:0]      sum2;
  logic signed [62:0]      nv;
  logic signed [49:0]      outv;

  // Arithmetic units
  logic               mul_start, mul_done, div_start, div_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic [DIV_W-1:0]   div_q;

  dsf_mul u_mul (.clk, .rst, .start(mul_start), .a(mul_a), .b(mul_b), .p(mul_p),
                 .done(mul_done));
  dsf_div u_div (.clk, .rst, .start(div_start),
                 .dividend(DIV_W'({over[HALF_W-1:0], {F{1'b0}}})),
                 .divisor(DIV_W'(edge_w)), .q(div_q), .done(div_done));

  // Combinational helpers
  logic signed [32:0] delta;
  logic [32:0]        delta_mag;
  logic [HALF_W-1:0]  e_new;
  logic [F+1:0]       three_m;
  logic [32:0]        m;
  logic signed [33:0] m_s;
  logic signed [34:0] change;
  logic signed [34:0] lim_s;
  logic signed [34:0] chg_c;
  logic [30:0]        chg_mag;
  logic signed [47:0] oc_s;
  logic [47:0]        s1_mag;
  logic signed [46:0] tm_s;
  logic [46:0]        tmp_mag;
  logic signed [62:0] ot_s;
  logic [62:0]        s2_mag;
  logic signed [62:0] nvm_s;
  logic signed [47:0] ct;
  logic [47:0]        ct_mag;
  logic signed [49:0] om_s;
  logic               overshoot;

  always_comb begin
    delta     = 33'(tgt) - 33'(pos);
    delta_mag = delta[32] ? 33'(-delta) : 33'(delta);
    e_new     = mul_p[RECIP5_SH +: HALF_W];
    three_m   = (F+2)'(3 * ONE) - {t, 1'b0};
    m         = mul_p[F +: 33];
    m_s       = signed'({1'b0, m});
    change    = 35'(pos) - 35'(aim);
    lim_s     = signed'(35'(com.lim));
    if (change > lim_s)       chg_c = lim_s;
    else if (change < -lim_s) chg_c = -lim_s;
    else                      chg_c = change;
    chg_mag   = chg[30] ? 31'(-chg) : 31'(chg);
    oc_s      = signed'({2'b0, mul_p[F +: 46]});
    s1_mag    = sum1[47] ? 48'(-sum1) : 48'(sum1);
    tm_s      = signed'({1'b0, mul_p[F +: 46]});
    tmp_mag   = tmp[46] ? 47'(-tmp) : 47'(tmp);
    ot_s      = signed'({2'b0, mul_p[F +: 61]});
    s2_mag    = sum2[62] ? 63'(-sum2) : 63'(sum2);
    nvm_s     = signed'({1'b0, mul_p[F +: 62]});
    ct        = 48'(chg) + 48'(tmp);
    ct_mag    = ct[47] ? 48'(-ct) : 48'(ct);
    om_s      = signed'({2'b0, mul_p[F +: 48]});
    overshoot = (aim > 34'(pos)) == (outv > 50'(aim));
  end

  // Multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      L_EDGE: begin mul_a = MUL_A_W'({half, 1'b0}); mul_b = RECIP5; end
      L_T2:   begin mul_a = MUL_A_W'(t);    mul_b = MUL_B_W'(t); end
      L_S:    begin mul_a = MUL_A_W'(t2);   mul_b = MUL_B_W'(three_m); end
      L_M:    begin mul_a = MUL_A_W'(over); mul_b = MUL_B_W'(s_f); end
      L_OC:   begin mul_a = MUL_A_W'(chg_mag); mul_b = MUL_B_W'(com.omega); end
      L_TEMP: begin mul_a = MUL_A_W'(s1_mag);  mul_b = MUL_B_W'(com.dt); end
      L_OT:   begin mul_a = MUL_A_W'(tmp_mag); mul_b = MUL_B_W'(com.omega); end
      L_NV:   begin mul_a = MUL_A_W'(s2_mag);  mul_b = MUL_B_W'(com.decay); end
      L_OUT:  begin mul_a = MUL_A_W'(ct_mag);  mul_b = MUL_B_W'(com.decay); end
      default: ;
    endcase
  end

  assign mul_start = !wait_q && (state inside {L_EDGE, L_T2, L_S, L_M, L_OC, L_TEMP,
                                               L_OT, L_NV, L_OUT});
  assign div_start = !wait_q && (state == L_TDIV);
  assign stat.busy = (state != L_IDLE);
  assign stat.pos  = pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= L_IDLE;
      wait_q <= 1'b0;
      pos    <= '0;
      vel    <= '0;
    end else begin
      if (mul_start || div_start) wait_q <= 1'b1;
      if (mul_done || div_done)   wait_q <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            tgt   <= target;
            state <= L_DZ;
          end
        end
        L_DZ: begin
          if (delta_mag <= 33'(half)) begin
            aim   <= 34'(pos);
            state <= L_CHG;
          end else begin
            over  <= delta_mag - 33'(half);
            neg   <= delta[32];
            state <= L_EDGE;
          end
        end
        L_EDGE: begin
          if (mul_done) begin
            edge_w <= e_new;
            if (e_new == '0 || over >= 33'(e_new)) begin
              t     <= (F+1)'(ONE);
              state <= L_T2;
            end else begin
              state <= L_TDIV;
            end
          end
        end
        L_TDIV: begin
          if (div_done) begin
            t     <= div_q[F:0];
            state <= L_T2;
          end
        end
        L_T2: begin
          if (mul_done) begin
            t2    <= mul_p[F +: F+1];
            state <= L_S;
          end
        end
        L_S: begin
          if (mul_done) begin
            s_f   <= mul_p[F +: F+1];
            state <= L_M;
          end
        end
        L_M: begin
          if (mul_done) begin
            aim   <= neg ? 34'(pos) - m_s : 34'(pos) + m_s;
            state <= L_CHG;
          end
        end
        L_CHG: begin
          chg   <= 31'(chg_c);
          goal  <= 34'(pos) - 34'(chg_c);
          state <= L_OC;
        end
        L_OC: begin
          if (mul_done) begin
            sum1  <= 48'(vel) + (chg[30] ? -oc_s : oc_s);
            state <= L_TEMP;
          end
        end
        L_TEMP: begin
          if (mul_done) begin
            tmp   <= sum1[47] ? -tm_s : tm_s;
            state <= L_OT;
          end
        end
        L_OT: begin
          if (mul_done) begin
            sum2  <= 63'(vel) - (tmp[46] ? -ot_s : ot_s);
            state <= L_NV;
          end
        end
        L_NV: begin
          if (mul_done) begin
            nv    <= sum2[62] ? -nvm_s : nvm_s;
            state <= L_OUT;
          end
        end
        L_OUT: begin
          if (mul_done) begin
            outv  <= 50'(goal) + (ct[47] ? -om_s : om_s);
            state <= L_FIN;
          end
        end
        L_FIN: begin
          // Passing the aim point snaps to it and kills the velocity
          if (overshoot) begin
            pos <= sat32(64'(aim));
            vel <= '0;
          end else begin
            pos <= sat32(64'(outv));
            vel <= sat32(64'(nv));
          end
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> rtl/dsf_chk.sv
`default_nettype none
// Port-level checks on the follower
module dsf_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire dsf_pkg::out_t out_data
);
  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // Reset leaves no result and an open input
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // One item at a time: an accepted item closes the input
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open while an item is in flight");
endmodule

bind deadzone_smoothdamp_follow dsf_chk u_chk (.*);
`default_nettype wire

>>> tb/tb.sv
`default_nettype none
module tb;
  import dsf_pkg::*;

  localparam longint unsigned FMASK = ONE - 1;

  // one directed row: stimulus plus an optional hand-worked result
  typedef struct {
    in_t  item;
    bit   known;
    out_t result;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DZ_X;
  logic [CFG_W-1:0] cfg_data = '0;

  // follower model state and register copies
  longint cam_x, cam_y, vel_x, vel_y;
  longint unsigned dzw_x, dzw_y, smooth_q;

  out_t pending_q[$];
  int   errors = 0;
  int   mismatches = 0;
  bit   quiet = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;

  deadzone_smoothdamp_follow DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("status: fail");
    $finish;
  end

  // fixed-point helpers
  function automatic longint unsigned umulq(longint unsigned a, longint unsigned b);
    return (a >> FRAC_BITS) * b + (((a & FMASK) * b) >> FRAC_BITS);
  endfunction

  function automatic longint unsigned magn(longint a);
    return (a < 0) ? longint'(0) - a : a;
  endfunction

  function automatic longint smulq(longint a, longint b);
    longint unsigned r;
    r = umulq(magn(a), magn(b));
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // aim offset beyond half the dead zone, faded in by smoothstep
  function automatic longint zone_offset(longint delta, longint unsigned half);
    longint unsigned a, over, edge_w, t, t2, s, m;
    a = magn(delta);
    if (a <= half) return 0;
    over = a - half;
    edge_w = (half * 2) / 5;
    if (edge_w == 0) t = ONE;
    else begin
      t = (over << FRAC_BITS) / edge_w;
      if (t > ONE) t = ONE;
    end
    t2 = (t * t) >> FRAC_BITS;
    s = (t2 * (3 * ONE - 2 * t)) >> FRAC_BITS;
    m = (over * s) >> FRAC_BITS;
    return (delta < 0) ? -longint'(m) : longint'(m);
  endfunction

  // one spring step on one axis
  function automatic longint spring_axis(longint cur, longint aim, inout longint vel,
                                         longint unsigned st, longint unsigned omega,
                                         longint unsigned decay, longint unsigned dt);
    longint lim, change, goal, temp, nv, pos;
    lim = st * 100;
    change = cur - aim;
    if (change > lim) change = lim;
    if (change < -lim) change = -lim;
    goal = cur - change;
    temp = smulq(vel + smulq(omega, change), dt);
    nv = smulq(vel - smulq(omega, temp), decay);
    pos = goal + smulq(change + temp, decay);
    if (((aim - cur) > 0) == (pos > aim)) begin
      pos = aim;
      nv = 0;
    end
    vel = clip32(nv);
    return clip32(pos);
  endfunction

  function automatic out_t follow_step(in_t it);
    longint unsigned st, omega, x, x2, x3, den, decay, dt;
    longint ax, ay;
    out_t r;
    dt = it.frame_time;
    r.moved = 1'b0;
    if (it.target_valid && dt != 0) begin
      st = (smooth_q < ST_FLOOR) ? ST_FLOOR : smooth_q;
      omega = (64'd2 << (2 * FRAC_BITS)) / st;
      x = umulq(dt, omega);
      decay = 0;
      if (x < X_CAP) begin
        x2 = umulq(x, x);
        x3 = umulq(x2, x);
        den = ONE + x + umulq(x2, C048) + umulq(x3, C235);
        decay = (ONE << FRAC_BITS) / den;
      end
      ax = cam_x + zone_offset(longint'($signed(it.target_x)) - cam_x, dzw_x >> 1);
      ay = cam_y + zone_offset(longint'($signed(it.target_y)) - cam_y, dzw_y >> 1);
      cam_x = spring_axis(cam_x, ax, vel_x, st, omega, decay, dt);
      cam_y = spring_axis(cam_y, ay, vel_y, st, omega, decay, dt);
      r.moved = 1'b1;
    end
    r.camera_x = cam_x[31:0];
    r.camera_y = cam_y[31:0];
    return r;
  endfunction

  // write all three registers; only called with the block idle
  task automatic set_regs(longint unsigned wx, longint unsigned wy, longint unsigned st);
    cfg_we <= 1'b1; cfg_index <= REG_DZ_X; cfg_data <= wx[23:0];
    @(posedge clk);
    cfg_index <= REG_DZ_Y; cfg_data <= wy[23:0];
    @(posedge clk);
    cfg_index <= REG_SMOOTH; cfg_data <= st[23:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    dzw_x = wx & 24'hFFFFFF;
    dzw_y = wy & 24'hFFFFFF;
    smooth_q = st & 23'h7FFFFF;
  endtask

  // offer one item and hold it until taken; it lowers valid only for a random gap, else drain does
  task automatic offer(in_t it, bit known, out_t result);
    out_t p;
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    p = follow_step(it);
    pending_q.push_back(known ? result : p);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (5) @(posedge clk);
  endtask

  function automatic longint unsigned pick_width();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return $urandom_range(1, 3);
      2: return 24'hFFFFFF;
      3: return $urandom_range(0, 24'hFFFFFF);
      default: return $urandom_range(0, 20) << 16;
    endcase
  endfunction

  function automatic longint unsigned pick_smooth();
    case ($urandom_range(0, 5))
      0: return 7;
      1: return 4194304;
      2: return $urandom_range(7, 4194304);
      default: return $urandom_range(1, 128) << 12;
    endcase
  endfunction

  function automatic logic [31:0] near_target(longint c, longint unsigned w);
    longint off;
    longint tpos;
    if ($urandom_range(0, 7) == 0) return $urandom;
    off = longint'($urandom_range(0, 32'hFFFFFF)) - 64'sd8388608;
    off = off + ((off < 0) ? -longint'(w) : longint'(w)) *
          longint'($urandom_range(0, 2)) / 2;
    tpos = clip32(c + off * longint'($urandom_range(1, 16)));
    return tpos[31:0];
  endfunction

  // results: compare with the oldest expectation
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result x=%0d y=%0d moved=%0b",
                                        out_data.camera_x, out_data.camera_y, out_data.moved);
      end else begin
        want = pending_q.pop_front();
        if (out_data !== want) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp x=%0d y=%0d moved=%0b got x=%0d y=%0d moved=%0b",
                     want.camera_x, want.camera_y, want.moved,
                     out_data.camera_x, out_data.camera_y, out_data.moved);
        end
      end
    end
  end

  // receiver: random short stalls, and one long hold counted here
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 600;
      out_stall <= 1'b1;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      if ($urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 19);
      out_stall <= 1'b0;
    end
  end

  // stimulus
  initial begin
    dir_row_t rows[8];
    in_t it;
    out_t none;
    longint unsigned cw[3][3];
    int n;
    none = '0;
    rows = '{
      '{'{1'b0, 32'sd0, 32'sd0, 16'd100}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
      '{'{1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'd0}, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
      '{'{1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{1'b1, 32'h80000000, 32'h80000000, 16'd1}, 1'b0, '0},
      '{'{1'b0, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF}, 1'b0, '0},
      '{'{1'b1, 32'sd0, 32'sd0, 16'h8000}, 1'b0, '0},
      '{'{1'b1, 32'h7FFFFFFF, 32'h80000000, 16'hFFFF}, 1'b0, '0},
      '{'{1'b1, 32'h80000000, 32'h7FFFFFFF, 16'hFFFF}, 1'b0, '0}
    };
    cw = '{'{0, 0, 65536}, '{24'hFFFFFF, 3, 7}, '{2, 24'hFFFFFF, 4194304}};
    cam_x = 0; cam_y = 0; vel_x = 0; vel_y = 0;
    dzw_x = 0; dzw_y = 0; smooth_q = ONE;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: the table under reset, extreme and opposite settings
    for (int p = 0; p < 3; p++) begin
      if (p > 0) set_regs(cw[p][0], cw[p][1], cw[p][2]);
      foreach (rows[i]) offer(rows[i].item, rows[i].known && p == 0, rows[i].result);
      drain();
    end

    // random phases, each under fresh settings
    for (int ph = 0; ph < 10; ph++) begin
      quiet = (ph == 9) || ($urandom_range(0, 4) == 0);
      set_regs(pick_width(), pick_width(), pick_smooth());
      if (ph == 3) hold_req = 1'b1;
      n = 0;
      while (n < 123) begin
        it.target_valid = ($urandom_range(0, 9) != 0);
        it.target_x = near_target(cam_x, dzw_x);
        it.target_y = near_target(cam_y, dzw_y);
        case ($urandom_range(0, 9))
          0: it.frame_time = 16'd0;
          1: it.frame_time = 16'($urandom);
          2: it.frame_time = 16'hFFFF;
          default: it.frame_time = 16'($urandom_range(1, 8000));
        endcase
        offer(it, 1'b0, none);
        n++;
      end
      drain();
    end

    in_valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> deadzone_smoothdamp_follow.f
rtl/dsf_pkg.sv
rtl/dsf_mul.sv
rtl/dsf_div.sv
rtl/dsf_lane.sv
rtl/deadzone_smoothdamp_follow.sv
rtl/dsf_chk.sv
tb/tb.sv
